// ----- rtl/bst_pkg.sv -----
// Shared types and sizing constants for the bearing slot table.
// Used by bst_mem, bst_cmp, bst_cmp_unit and bearing_slot_table; depends on nothing.
package bst_pkg;

  localparam int TABLE_DEPTH = 256;
  localparam int ANGLE_BITS  = 16;
  localparam int REF_W       = 16;
  localparam int TOL_W       = 15;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef logic [ANGLE_BITS-1:0] angle_t;
  typedef logic [REF_W-1:0]      ref_t;
  typedef logic [TOL_W-1:0]      tol_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  typedef struct packed {
    angle_t key;
    ref_t   pref;
  } entry_t;

  // Flags from the shared compare unit
  typedef struct packed {
    logic le;    // stored key <= bearing
    logic eq;    // stored key == bearing
    logic near;  // circular distance within tolerance
  } cmp_t;

endpackage

// ----- rtl/bst_mem.sv -----
// Entry store for the bearing slot table: one write port, one registered read port.
// Depends on bst_pkg.
module bst_mem (
  input  logic            clk,
  input  logic            we,
  input  bst_pkg::addr_t  waddr,
  input  bst_pkg::entry_t wdata,
  input  bst_pkg::addr_t  raddr,
  output bst_pkg::entry_t rdata
);
  import bst_pkg::*;

  entry_t mem [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bst_cmp.sv -----
// Window test of the held bearing: does the tolerance reach past either end of the circle.
// Depends on bst_pkg.
module bst_cmp (
  input  bst_pkg::angle_t bearing,
  input  bst_pkg::tol_t   tol,
  output logic            wrap_hi,
  output logic            wrap_lo
);
  import bst_pkg::*;

  logic [ANGLE_BITS:0] up_sum;

  // carry out of bearing + tolerance means the window reaches past the top of the circle
  assign up_sum  = {1'b0, bearing} + (ANGLE_BITS + 1)'(tol);
  assign wrap_hi = up_sum[ANGLE_BITS];
  assign wrap_lo = (bearing <= ANGLE_BITS'(tol));

endmodule

// ----- rtl/bst_cmp_unit.sv -----
// Shared compare unit: ordering, equality and circular tolerance test of one key.
// Depends on bst_pkg.
module bst_cmp_unit (
  input  bst_pkg::angle_t key,
  input  bst_pkg::angle_t bearing,
  input  bst_pkg::tol_t   tol,
  output bst_pkg::cmp_t   flags
);
  import bst_pkg::*;

  angle_t d_up;
  angle_t d_dn;
  angle_t d_min;

  always_comb begin
    d_up       = key - bearing;
    d_dn       = bearing - key;
    d_min      = (d_up < d_dn) ? d_up : d_dn;
    flags.le   = (key <= bearing);
    flags.eq   = (key == bearing);
    flags.near = (d_min <= ANGLE_BITS'(tol));
  end

endmodule

// ----- rtl/bearing_slot_table.sv -----
// Bearing slot table top level: sequencer, tolerance register and result register.
// Depends on bst_pkg, bst_mem, bst_cmp_unit and bst_cmp.
//
// Command channel: an item (func, bearing, profile_ref) is taken at a rising edge
//   with start high and busy low; busy holds high until the result beat.
// Result channel: done pulses for one cycle with found, slot_bearing, matched_ref
//   and insert_status; the receiver cannot stall, so each beat is presented once.
//   busy is low again in the done cycle, so the next command may be taken there.
// Config: cfg_we writes cfg_wdata into the half-beam tolerance; write it only
//   while busy is low and no done is pending.
// Steps: a binary search over the held entries, one read per cycle from the entry
//   memory through the shared compare unit. Lookup then tries the key above the
//   bearing and, if that misses, the key at or below; an empty table answers at
//   the end of the search. Insert replaces, drops or places an entry at the end,
//   or else moves the held entries above the slot up one by one before placing it.
// Reset: rst clears the entry count, the tolerance and the sequencer; the
//   memory is not cleared, and entries at or above the count never reach a result.
module bearing_slot_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        func,
  input  logic [15:0] bearing,
  input  logic [15:0] profile_ref,
  input  logic        cfg_we,
  input  logic [14:0] cfg_wdata,
  output logic        done,
  output logic        found,
  output logic [15:0] slot_bearing,
  output logic [15:0] matched_ref,
  output logic [1:0]  insert_status
);
  import bst_pkg::*;

  localparam int SUM_W = CNT_W + 1;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_SEARCH  = 3'd1;
  localparam logic [2:0] S_INS_CHK = 3'd2;
  localparam logic [2:0] S_SHIFT   = 3'd3;
  localparam logic [2:0] S_PUT     = 3'd4;
  localparam logic [2:0] S_LK_A    = 3'd5;
  localparam logic [2:0] S_LK_B    = 3'd6;

  localparam logic [1:0] ST_ADDED    = 2'd0;
  localparam logic [1:0] ST_REPLACED = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;

  localparam logic FUNC_INSERT = 1'b0;

  // Registers
  logic [2:0] state;
  cnt_t       lo;
  cnt_t       hi;
  addr_t      mid;
  cnt_t       idx;
  cnt_t       sh;
  logic       try_a;
  logic       func_q;
  angle_t     bq;
  ref_t       pref_q;
  cnt_t       cnt;
  tol_t       hbw;

  // Next values
  logic [2:0] state_next;
  cnt_t       lo_next;
  cnt_t       hi_next;
  addr_t      mid_next;
  cnt_t       idx_next;
  cnt_t       sh_next;
  logic       try_a_next;

  // Search and address helpers
  cnt_t                 lo_s;
  cnt_t                 hi_s;
  cnt_t                 lo_s_m1;
  logic [SUM_W-1:0]     mid_sum;
  cnt_t                 cnt_half;
  cnt_t                 cnt_m1;
  cnt_t                 idx_m1;
  cnt_t                 sh_m1;
  cnt_t                 sh_m2;
  logic                 wrap_hi;
  logic                 wrap_lo;

  // Memory port and compare unit
  addr_t  rd_addr;
  entry_t rd_data;
  logic   mem_we;
  addr_t  wr_addr;
  entry_t wr_data;
  cmp_t   cmp;
  logic   cnt_inc;

  // Result beat
  logic   em;
  logic   em_found;
  angle_t em_slot;
  ref_t   em_ref;
  logic [1:0] em_st;

  assign busy = (state != S_IDLE);

  assign cnt_half = cnt >> 1;
  assign cnt_m1   = cnt - CNT_W'(1);
  assign idx_m1   = idx - CNT_W'(1);
  assign sh_m1    = sh - CNT_W'(1);
  assign sh_m2    = sh - CNT_W'(2);

  bst_mem u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_addr),
    .wdata (wr_data),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  bst_cmp_unit u_cmp (
    .key     (rd_data.key),
    .bearing (bq),
    .tol     (hbw),
    .flags   (cmp)
  );

  bst_cmp u_wrap (
    .bearing (bq),
    .tol     (hbw),
    .wrap_hi (wrap_hi),
    .wrap_lo (wrap_lo)
  );

  always_comb begin
    state_next = state;
    lo_next    = lo;
    hi_next    = hi;
    mid_next   = mid;
    idx_next   = idx;
    sh_next    = sh;
    try_a_next = try_a;
    rd_addr    = mid;
    mem_we     = 1'b0;
    wr_addr    = idx[ADDR_W-1:0];
    wr_data    = '{key: bq, pref: pref_q};
    cnt_inc    = 1'b0;
    em         = 1'b0;
    em_found   = 1'b0;
    em_slot    = bq;
    em_ref     = '0;
    em_st      = ST_ADDED;
    lo_s       = lo;
    hi_s       = hi;
    lo_s_m1    = lo - CNT_W'(1);
    mid_sum    = '0;

    case (state)
      S_IDLE: begin
        if (start) begin
          // open the search window over all held entries
          state_next = S_SEARCH;
          lo_next    = '0;
          hi_next    = cnt;
          mid_next   = cnt_half[ADDR_W-1:0];
          rd_addr    = cnt_half[ADDR_W-1:0];
        end
      end

      S_SEARCH: begin
        if (lo < hi) begin
          if (cmp.le) begin
            lo_s = CNT_W'(mid) + CNT_W'(1);
          end else begin
            hi_s = CNT_W'(mid);
          end
        end
        lo_s_m1 = lo_s - CNT_W'(1);
        lo_next = lo_s;
        hi_next = hi_s;
        if (lo_s < hi_s) begin
          mid_sum  = SUM_W'(lo_s) + SUM_W'(hi_s);
          mid_next = mid_sum[ADDR_W:1];
          rd_addr  = mid_sum[ADDR_W:1];
        end else begin
          // lo_s is the first slot whose key lies above the bearing
          idx_next = lo_s;
          if (func_q == FUNC_INSERT) begin
            rd_addr    = lo_s_m1[ADDR_W-1:0];
            state_next = S_INS_CHK;
          end else if (cnt == '0) begin
            em         = 1'b1;
            state_next = S_IDLE;
          end else begin
            try_a_next = (lo_s < cnt) || wrap_hi;
            rd_addr    = (lo_s < cnt) ? lo_s[ADDR_W-1:0] : '0;
            state_next = S_LK_A;
          end
        end
      end

      S_INS_CHK: begin
        if ((idx != '0) && cmp.eq) begin
          // same bearing held: overwrite its reference
          mem_we     = 1'b1;
          wr_addr    = idx_m1[ADDR_W-1:0];
          em         = 1'b1;
          em_st      = ST_REPLACED;
          state_next = S_IDLE;
        end else if (cnt >= CNT_W'(TABLE_DEPTH)) begin
          em         = 1'b1;
          em_st      = ST_DROPPED;
          state_next = S_IDLE;
        end else if (cnt > idx) begin
          rd_addr    = cnt_m1[ADDR_W-1:0];
          sh_next    = cnt;
          state_next = S_SHIFT;
        end else begin
          mem_we     = 1'b1;
          cnt_inc    = 1'b1;
          em         = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_SHIFT: begin
        // move one entry up, fetch the one below it
        mem_we  = 1'b1;
        wr_addr = sh[ADDR_W-1:0];
        wr_data = rd_data;
        if (sh_m1 > idx) begin
          rd_addr = sh_m2[ADDR_W-1:0];
          sh_next = sh_m1;
        end else begin
          state_next = S_PUT;
        end
      end

      S_PUT: begin
        mem_we     = 1'b1;
        cnt_inc    = 1'b1;
        em         = 1'b1;
        state_next = S_IDLE;
      end

      S_LK_A: begin
        if (try_a && cmp.near) begin
          em         = 1'b1;
          em_found   = 1'b1;
          em_slot    = rd_data.key;
          em_ref     = rd_data.pref;
          state_next = S_IDLE;
        end else if (idx != '0) begin
          rd_addr    = idx_m1[ADDR_W-1:0];
          state_next = S_LK_B;
        end else if (wrap_lo) begin
          rd_addr    = cnt_m1[ADDR_W-1:0];
          state_next = S_LK_B;
        end else begin
          em         = 1'b1;
          state_next = S_IDLE;
        end
      end

      S_LK_B: begin
        em         = 1'b1;
        state_next = S_IDLE;
        if (cmp.near) begin
          em_found = 1'b1;
          em_slot  = rd_data.key;
          em_ref   = rd_data.pref;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      hbw   <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= em;
      if (cnt_inc) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cfg_we) begin
        hbw <= cfg_wdata;
      end
    end
  end

  // Working and result payload
  always_ff @(posedge clk) begin
    lo    <= lo_next;
    hi    <= hi_next;
    mid   <= mid_next;
    idx   <= idx_next;
    sh    <= sh_next;
    try_a <= try_a_next;
    if ((state == S_IDLE) && start) begin
      func_q <= func;
      bq     <= bearing;
      pref_q <= profile_ref;
    end
    if (em) begin
      found         <= em_found;
      slot_bearing  <= em_slot;
      matched_ref   <= em_ref;
      insert_status <= em_st;
    end
  end

  // The count never passes the table depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  // The count grows by at most one per cycle
  a_cnt_step: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> (cnt == $past(cnt)) || (cnt == $past(cnt) + CNT_W'(1)))
    else $error("entry count jumped");

  // An accepted command always leaves idle
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("command accepted without going busy");

  // A result beat only follows work in progress
  a_done_after_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> ($past(busy) && !busy))
    else $error("result beat without preceding work");

  // A hit never carries an insert status
  a_found_status: assert property (@(posedge clk) disable iff (rst)
    (done && found) |-> (insert_status == ST_ADDED))
    else $error("lookup hit with insert status");

endmodule

// ----- tb/tb_bearing_slot_table.sv -----
// Self-checking testbench for bearing_slot_table: sorted circular-angle table with
// insert/replace/drop and tolerance lookup, predicted in-bench and checked beat by beat.
// Depends on bst_pkg and the bearing_slot_table RTL only.
module tb_bearing_slot_table;
  import bst_pkg::*;

  typedef enum logic {OP_INSERT = 1'b0, OP_LOOKUP = 1'b1} op_e;
  typedef enum logic [1:0] {
    INS_ADDED    = 2'd0,
    INS_REPLACED = 2'd1,
    INS_DROPPED  = 2'd2
  } ins_e;

  typedef struct packed {
    op_e    op;
    angle_t brg;
    ref_t   pref;
  } cmd_t;

  typedef struct packed {
    logic       hit;
    angle_t     slot;
    ref_t       mref;
    logic [1:0] status;
  } slot_res_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        func = 1'b0;
  logic [15:0] bearing = '0;
  logic [15:0] profile_ref = '0;
  logic        cfg_we = 1'b0;
  logic [14:0] cfg_wdata = '0;
  logic        busy;
  logic        done;
  logic        found;
  logic [15:0] slot_bearing;
  logic [15:0] matched_ref;
  logic [1:0]  insert_status;

  // Commands waiting to be driven, results predicted for accepted commands
  cmd_t      pending_cmds[$];
  slot_res_t expected_slots[$];
  // Bearings already sent as inserts; reused for replaces and near lookups
  angle_t    bearing_pool[$];

  // Shadow copy of the table and the tolerance register
  angle_t      key_tab[TABLE_DEPTH];
  ref_t        ref_tab[TABLE_DEPTH];
  int          n_entries = 0;
  tol_t        tol_now = '0;

  int          idle_pct = 0;
  int          err_count = 0;

  bearing_slot_table u_top (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .func          (func),
    .bearing       (bearing),
    .profile_ref   (profile_ref),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .done          (done),
    .found         (found),
    .slot_bearing  (slot_bearing),
    .matched_ref   (matched_ref),
    .insert_status (insert_status)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Watchdog: far beyond the slowest legal run (full-table inserts, 81% sender gaps)
  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end

  task automatic log_mismatch(input string msg);
    err_count++;
    $display("MISMATCH: %s", msg);
  endtask

  // Circular distance between two angles, compared against the tolerance
  function automatic logic near_angle(input angle_t a, input angle_t b);
    angle_t d1, d2, d;
    d1 = a - b;
    d2 = b - a;
    d  = (d1 < d2) ? d1 : d2;
    return d <= {1'b0, tol_now};
  endfunction

  // Apply one command to the shadow table and return the result it yields
  function automatic slot_res_t apply_slot_cmd(input cmd_t c);
    slot_res_t r;
    int        idx;
    int        hit;
    int        n;
    r.hit    = 1'b0;
    r.slot   = c.brg;
    r.mref   = '0;
    r.status = INS_ADDED;
    n   = n_entries;
    idx = 0;
    hit = -1;
    // Find the first key strictly above the bearing
    while (idx < n && key_tab[idx] <= c.brg) idx++;
    if (c.op == OP_INSERT) begin
      if (idx > 0 && key_tab[idx-1] == c.brg) begin
        ref_tab[idx-1] = c.pref;
        r.status = INS_REPLACED;
      end else if (n >= TABLE_DEPTH) begin
        r.status = INS_DROPPED;
      end else begin
        for (int i = n; i > idx; i--) begin
          key_tab[i] = key_tab[i-1];
          ref_tab[i] = ref_tab[i-1];
        end
        key_tab[idx] = c.brg;
        ref_tab[idx] = c.pref;
        n_entries = n + 1;
      end
    end else if (n > 0) begin
      // Key above first; with none above, wrap to the lowest key near the top of the circle
      if (idx < n) begin
        if (near_angle(c.brg, key_tab[idx])) hit = idx;
      end else if ({1'b0, c.brg} + {2'b00, tol_now} >= 17'h10000) begin
        if (near_angle(c.brg, key_tab[0])) hit = 0;
      end
      // Then the key at or below; with none below, wrap to the highest key near zero
      if (hit < 0) begin
        if (idx > 0) begin
          if (near_angle(c.brg, key_tab[idx-1])) hit = idx - 1;
        end else if (c.brg <= {1'b0, tol_now}) begin
          if (near_angle(c.brg, key_tab[n-1])) hit = n - 1;
        end
      end
      if (hit >= 0) begin
        r.hit  = 1'b1;
        r.slot = key_tab[hit];
        r.mref = ref_tab[hit];
      end
    end
    return r;
  endfunction

  // Command driver: predict on every accepted beat, hold start while busy,
  // and insert random gaps before raising start for the next command.
  always @(posedge clk) begin : cmd_driver
    cmd_t taken;
    cmd_t nxt;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        taken.op   = op_e'(func);
        taken.brg  = bearing;
        taken.pref = profile_ref;
        expected_slots.push_back(apply_slot_cmd(taken));
      end
      // A command still waiting on busy keeps its fields and start
      if (!(start && busy)) begin
        if (pending_cmds.size() != 0 && $urandom_range(99) >= idle_pct) begin
          nxt = pending_cmds.pop_front();
          start       <= 1'b1;
          func        <= nxt.op;
          bearing     <= nxt.brg;
          profile_ref <= nxt.pref;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each done beat is matched against the oldest prediction
  always @(posedge clk) begin : result_monitor
    slot_res_t want;
    if (!rst && done) begin
      if (expected_slots.size() == 0) begin
        log_mismatch($sformatf("result beat with nothing expected, slot_bearing %h",
                               slot_bearing));
      end else begin
        want = expected_slots.pop_front();
        if (found !== want.hit)
          log_mismatch($sformatf("found %b, want %b (bearing %h)", found, want.hit,
                                 want.slot));
        if (slot_bearing !== want.slot)
          log_mismatch($sformatf("slot_bearing %h, want %h", slot_bearing, want.slot));
        if (matched_ref !== want.mref)
          log_mismatch($sformatf("matched_ref %h, want %h (slot %h)", matched_ref,
                                 want.mref, want.slot));
        if (insert_status !== want.status)
          log_mismatch($sformatf("insert_status %0d, want %0d (bearing %h)",
                                 insert_status, want.status, want.slot));
      end
    end
  end

  task automatic queue_cmd(input op_e op, input angle_t brg, input ref_t pref);
    cmd_t c;
    c.op   = op;
    c.brg  = brg;
    c.pref = pref;
    pending_cmds.push_back(c);
    if (op == OP_INSERT) bearing_pool.push_back(brg);
  endtask

  // Block until every queued command has been taken and every result has come back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || start || expected_slots.size() != 0);
  endtask

  // Write the tolerance only once the table has gone quiet
  task automatic set_tolerance(input tol_t v);
    wait_idle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tol_now = v;
    @(negedge clk);
  endtask

  // Angle within eight units of zero on either side
  function automatic angle_t wrap_bearing();
    int unsigned e;
    e = $urandom_range(15);
    return (e < 8) ? angle_t'(e) : angle_t'(16'hFFF0 + e);
  endfunction

  // Random mix: inserts (fresh, reused, or near the wrap point) and lookups
  // (mostly close to a stored bearing so the tolerance window gets exercised).
  task automatic run_random(input int count, input int ins_pct);
    int          t;
    int          ofs;
    int unsigned sel;
    angle_t      b;
    ref_t        p;
    t = int'(tol_now);
    for (int k = 0; k < count; k++) begin
      p   = ref_t'($urandom);
      sel = $urandom_range(99);
      if ($urandom_range(99) < ins_pct) begin
        if (sel < 25 && bearing_pool.size() != 0)
          b = bearing_pool[$urandom_range(bearing_pool.size() - 1)];
        else if (sel < 35)
          b = wrap_bearing();
        else
          b = angle_t'($urandom);
        queue_cmd(OP_INSERT, b, p);
      end else begin
        if (sel < 60 && bearing_pool.size() != 0) begin
          ofs = int'($urandom_range(2 * t + 4)) - (t + 2);
          b   = angle_t'(int'(bearing_pool[$urandom_range(bearing_pool.size() - 1)]) + ofs);
        end else if (sel < 70) begin
          b = wrap_bearing();
        end else begin
          b = angle_t'($urandom);
        end
        queue_cmd(OP_LOOKUP, b, p);
      end
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    idle_pct = 21;
    // Exact-match tolerance: empty table, adds, a replace, hits and a near miss
    set_tolerance(15'd0);
    queue_cmd(OP_LOOKUP, 16'h1234, 16'h0000);
    queue_cmd(OP_INSERT, 16'h0010, 16'hFFFF);
    queue_cmd(OP_INSERT, 16'hFFF8, 16'h0000);
    queue_cmd(OP_INSERT, 16'h8000, 16'h1234);
    queue_cmd(OP_INSERT, 16'h8000, 16'hABCD);
    queue_cmd(OP_LOOKUP, 16'h8000, 16'h0000);
    queue_cmd(OP_LOOKUP, 16'h8001, 16'h0000);
    queue_cmd(OP_LOOKUP, 16'h0010, 16'h0000);

    // Wrap above the top key to the lowest one (wins over the closer key below),
    // plus hits and misses right at the tolerance edge
    set_tolerance(15'd32);
    queue_cmd(OP_LOOKUP, 16'hFFFF, 16'h0000);
    queue_cmd(OP_LOOKUP, 16'h0003, 16'h0000);
    queue_cmd(OP_LOOKUP, 16'h8020, 16'h0000);
    queue_cmd(OP_LOOKUP, 16'h8021, 16'h0000);
    queue_cmd(OP_LOOKUP, 16'hC000, 16'h0000);

    // Wrap below the lowest key to the highest one; wrapped try misses, key below hits
    set_tolerance(15'd12);
    queue_cmd(OP_LOOKUP, 16'h0001, 16'h0000);
    queue_cmd(OP_LOOKUP, 16'hFFFC, 16'h0000);

    // Widest tolerance; extreme bearings stored at both ends of the circle
    set_tolerance(15'h7FFF);
    queue_cmd(OP_LOOKUP, 16'h4000, 16'h0000);
    queue_cmd(OP_INSERT, 16'h0000, 16'h0001);
    queue_cmd(OP_INSERT, 16'hFFFF, 16'hFFFE);
    queue_cmd(OP_LOOKUP, 16'hFFFF, 16'h0000);
    queue_cmd(OP_LOOKUP, 16'h0000, 16'h0000);
    queue_cmd(OP_LOOKUP, 16'h8000, 16'h0000);

    // Random part: moderate gaps while the table grows
    set_tolerance(tol_t'($urandom_range(1, 600)));
    run_random(240, 65);

    // Heavy sender gaps, insert-heavy so the table fills and starts dropping
    idle_pct = 81;
    set_tolerance(tol_t'($urandom_range(0, 40)));
    run_random(240, 85);

    // Back to back at both tolerance extremes on a full table
    idle_pct = 0;
    set_tolerance(15'd0);
    run_random(120, 40);
    set_tolerance(15'h7FFF);
    run_random(125, 40);

    wait_idle();
    // Let any stray beat surface before judging
    repeat (40) @(posedge clk);
    if (err_count == 0 && expected_slots.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
